// File: hdl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the kicker charge/kick controller.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	// register indexes on the write port
	localparam logic [CfgIdxW-1:0] REG_PWM_PERIOD = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DUTY_STEP = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BLINK_ON = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_BLINK_OFF = 2'd3;

	// register reset values
	localparam logic [7:0] PWM_PERIOD_RST = 8'd30;
	localparam logic [4:0] DUTY_STEP_RST = 5'd3;
	localparam logic [7:0] BLINK_ON_RST = 8'd20;
	localparam logic [7:0] BLINK_OFF_RST = 8'd30;

	// command characters
	localparam logic [7:0] CMD_DRIB = 8'h64;       // 'd'
	localparam logic [7:0] CMD_KICK = 8'h6b;       // 'k'
	localparam logic [7:0] CMD_CHARGE = 8'h63;     // 'c'
	localparam logic [7:0] CMD_DISCHARGE = 8'h70;  // 'p'
	localparam logic [7:0] CMD_STOP = 8'h73;       // 's'
	localparam logic [7:0] CMD_BEAM_ARM = 8'h62;   // 'b'
	localparam logic [7:0] CMD_FULL_ARM = 8'h66;   // 'f'

	localparam logic [7:0] CHAR_ZERO = 8'h30;      // '0'
	localparam logic [7:0] CHAR_NINE = 8'h39;      // '9'

	typedef struct packed {
		logic [7:0] pwm_period;
		logic [4:0] duty_step;
		logic [7:0] blink_on_limit;
		logic [7:0] blink_off_limit;
	} cfg_t;

	typedef struct packed {
		logic       packet_valid;
		logic [7:0] cmd;
		logic [7:0] arg_char;
		logic       beam_broken;
		logic       charge_done_n;
	} item_t;

	typedef struct packed {
		logic kick_fire;
		logic discharge_pulse;
		logic recharge_toggle;
		logic charge_on;
		logic dribbler_on;
		logic indicator_on;
	} result_t;

endpackage

// File: hdl/kcc_cfg.sv
// ----------------------------------------------------------------------------
// kcc_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module kcc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [kcc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [kcc_pkg::CfgDataW-1:0] cfg_data,
	output kcc_pkg::cfg_t               cfg
);
	import kcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period <= PWM_PERIOD_RST;
			cfg_q.duty_step <= DUTY_STEP_RST;
			cfg_q.blink_on_limit <= BLINK_ON_RST;
			cfg_q.blink_off_limit <= BLINK_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_PERIOD: cfg_q.pwm_period <= cfg_data;
				REG_DUTY_STEP: cfg_q.duty_step <= cfg_data[4:0];
				REG_BLINK_ON: cfg_q.blink_on_limit <= cfg_data;
				REG_BLINK_OFF: cfg_q.blink_off_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/kcc_core.sv
// ----------------------------------------------------------------------------
// kcc_core
// Controller state and the next-state/result logic for one control pass.
// ----------------------------------------------------------------------------
module kcc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  kcc_pkg::item_t   item,
	input  kcc_pkg::cfg_t    cfg,
	output kcc_pkg::result_t res
);
	import kcc_pkg::*;

	logic [7:0] pwm_count_q, duty_high_q, blink_count_q;
	logic       indicator_q, charging_q, maintain_q, beam_armed_q, full_armed_q;

	logic [7:0] pwm_count_d, duty_high_d, blink_count_d;
	logic       indicator_d, charging_d, maintain_d, beam_armed_d, full_armed_d;
	logic       kick, discharge, toggle, drib;
	logic [8:0] duty_prod;
	logic       full;

	// step (<= 31) times digit (<= 9) fits in 9 bits
	assign duty_prod = 9'(cfg.duty_step) * 9'(item.arg_char[3:0]);
	assign full = !item.charge_done_n;

	always_comb begin
		pwm_count_d = pwm_count_q;
		duty_high_d = duty_high_q;
		blink_count_d = blink_count_q;
		indicator_d = indicator_q;
		charging_d = charging_q;
		maintain_d = maintain_q;
		beam_armed_d = beam_armed_q;
		full_armed_d = full_armed_q;
		kick = 1'b0;
		discharge = 1'b0;
		toggle = 1'b0;

		// blink counter
		if (blink_count_q <= cfg.blink_on_limit) begin
			indicator_d = 1'b1;
			blink_count_d = blink_count_q + 8'd1;
		end else if (blink_count_q <= cfg.blink_off_limit) begin
			indicator_d = 1'b0;
			blink_count_d = blink_count_q + 8'd1;
		end else begin
			blink_count_d = 8'd0;
		end

		// dribbler PWM
		drib = pwm_count_q <= duty_high_q;
		pwm_count_d = ((pwm_count_q >= cfg.pwm_period) ? 8'd0 : pwm_count_q) + 8'd1;

		if (item.packet_valid) begin
			unique case (item.cmd)
				CMD_DRIB: begin
					if (item.arg_char >= CHAR_ZERO && item.arg_char <= CHAR_NINE) begin
						duty_high_d = duty_prod[8] ? 8'hff : duty_prod[7:0];
					end
				end
				CMD_KICK: begin
					charging_d = 1'b0;
					kick = 1'b1;
					beam_armed_d = 1'b0;
					maintain_d = 1'b0;
					indicator_d = 1'b1;
				end
				CMD_CHARGE: begin
					charging_d = 1'b1;
					maintain_d = 1'b1;
				end
				CMD_DISCHARGE: begin
					charging_d = 1'b0;
					discharge = 1'b1;
					maintain_d = 1'b0;
				end
				CMD_STOP: begin
					charging_d = 1'b0;
					beam_armed_d = 1'b0;
					maintain_d = 1'b0;
				end
				CMD_BEAM_ARM: begin
					indicator_d = 1'b1;
					charging_d = 1'b1;
					beam_armed_d = 1'b1;
					maintain_d = 1'b1;
				end
				CMD_FULL_ARM: begin
					indicator_d = 1'b1;
					charging_d = 1'b1;
					full_armed_d = 1'b1;
					maintain_d = 1'b1;
				end
				default: ;
			endcase
		end

		// full-charge arm turns into a beam arm
		if (full_armed_d && full) begin
			beam_armed_d = 1'b1;
			full_armed_d = 1'b0;
		end

		if (maintain_d && full) begin
			toggle = 1'b1;
			charging_d = 1'b1;
		end

		// beam kick
		if (item.beam_broken && beam_armed_d) begin
			beam_armed_d = 1'b0;
			charging_d = 1'b0;
			kick = 1'b1;
			indicator_d = 1'b1;
			maintain_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_count_q <= '0;
			duty_high_q <= '0;
			blink_count_q <= '0;
			indicator_q <= 1'b1;
			charging_q <= 1'b0;
			maintain_q <= 1'b0;
			beam_armed_q <= 1'b0;
			full_armed_q <= 1'b0;
		end else if (adv) begin
			pwm_count_q <= pwm_count_d;
			duty_high_q <= duty_high_d;
			blink_count_q <= blink_count_d;
			indicator_q <= indicator_d;
			charging_q <= charging_d;
			maintain_q <= maintain_d;
			beam_armed_q <= beam_armed_d;
			full_armed_q <= full_armed_d;
		end
	end

	assign res.kick_fire = kick;
	assign res.discharge_pulse = discharge;
	assign res.recharge_toggle = toggle;
	assign res.charge_on = charging_d;
	assign res.dribbler_on = drib;
	assign res.indicator_on = indicator_d;

endmodule

// File: hdl/kicker_charge_kick_controller.sv
// ----------------------------------------------------------------------------
// kicker_charge_kick_controller
// Kicker charge/kick controller: one control pass per accepted item.
// ----------------------------------------------------------------------------
// Each accepted item is one control pass. It is captured in an input register,
// and once the result register is free the pass is evaluated against the controller
// state (PWM and blink counters, charge/maintain/arm flags) by combinational
// compare, multiply and select logic and written into a result register, while the
// state updates in the same edge. Throughput is one item per cycle while
// result_stall does not hold a result, limited only by the state feedback of the
// pass logic. A result held by result_stall backs up into the input register and
// then asserts item_stall; no transaction is lost or repeated. Configuration
// registers (index 0 PWM period, 1 duty step, 2 blink-on limit, 3 blink-off
// limit) are written through cfg_we/cfg_index/cfg_data and must only be changed
// while the block is idle.
// ----------------------------------------------------------------------------
module kicker_charge_kick_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [kcc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kcc_pkg::CfgDataW-1:0] cfg_data,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         packet_valid,
	input  logic [7:0]                   cmd,
	input  logic [7:0]                   arg_char,
	input  logic                         beam_broken,
	input  logic                         charge_done_n,
	// result channel
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         kick_fire,
	output logic                         discharge_pulse,
	output logic                         recharge_toggle,
	output logic                         charge_on,
	output logic                         dribbler_on,
	output logic                         indicator_on
);
	import kcc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t result_q;
	logic    result_valid_q;
	logic    adv;

	kcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the pass in the input register completes when the result register is free
	assign adv = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.packet_valid <= packet_valid;
			item_s1.cmd <= cmd;
			item_s1.arg_char <= arg_char;
			item_s1.beam_broken <= beam_broken;
			item_s1.charge_done_n <= charge_done_n;
		end
	end

	kcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_valid_q || !result_stall) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign kick_fire = result_q.kick_fire;
	assign discharge_pulse = result_q.discharge_pulse;
	assign recharge_toggle = result_q.recharge_toggle;
	assign charge_on = result_q.charge_on;
	assign dribbler_on = result_q.dribbler_on;
	assign indicator_on = result_q.indicator_on;

endmodule

// File: hdl/kcc_checker.sv
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks of the kicker controller, bound to the top level.
// ----------------------------------------------------------------------------
module kcc_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_stall,
	input logic kick_fire,
	input logic discharge_pulse,
	input logic recharge_toggle,
	input logic charge_on,
	input logic indicator_on
);

	// a held result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a discharge leaves the charger off and no maintain pulse
	a_discharge: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && discharge_pulse |-> !charge_on && !recharge_toggle)
		else $error("charger active after discharge");

	// a maintain pulse re-enables charging unless a beam kick followed
	a_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && recharge_toggle && !kick_fire |-> charge_on)
		else $error("maintain pulse without charge enable");

	// every kick leaves the indicator lit
	a_kick_ind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kick_fire |-> indicator_on)
		else $error("indicator off after kick");

endmodule

bind kicker_charge_kick_controller kcc_checker u_kcc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.kick_fire       (kick_fire),
	.discharge_pulse (discharge_pulse),
	.recharge_toggle (recharge_toggle),
	.charge_on       (charge_on),
	.indicator_on    (indicator_on)
);
